/* design/ptpd_pkg.sv */
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared types and constants for the point transform / perspective divide.
// ----------------------------------------------------------------------------
package ptpd_pkg;

  localparam int NUM_REGS = 8;

  typedef enum logic [2:0] {
    REG_COL0_XY = 3'd0,
    REG_COL0_ZW = 3'd1,
    REG_COL1_XY = 3'd2,
    REG_COL1_ZW = 3'd3,
    REG_COL2_XY = 3'd4,
    REG_COL2_ZW = 3'd5,
    REG_COL3_XY = 3'd6,
    REG_COL3_ZW = 3'd7
  } reg_idx_t;

  localparam logic [63:0] RST_COL0_XY = 64'd65536;
  localparam logic [63:0] RST_COL0_ZW = 64'd0;
  localparam logic [63:0] RST_COL1_XY = 64'd281474976710656;
  localparam logic [63:0] RST_COL1_ZW = 64'd0;
  localparam logic [63:0] RST_COL2_XY = 64'd0;
  localparam logic [63:0] RST_COL2_ZW = 64'd65536;
  localparam logic [63:0] RST_COL3_XY = 64'd0;
  localparam logic [63:0] RST_COL3_ZW = 64'd281474976710656;

  typedef logic [NUM_REGS-1:0][63:0] cfg_bank_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               out_last;
    logic               saturated;
  } out_t;

endpackage

/* design/point_transform_perspective_divide.sv */
// ----------------------------------------------------------------------------
// point_transform_perspective_divide
// 4x4 homogeneous point transform with divide by w and saturation.
// ----------------------------------------------------------------------------
// Pipeline: the MAC stages, then the one-bit-per-stage divider and its output
// register. Throughput: one transaction per cycle; the whole pipe holds while
// the output is stalled. Reset clears all valid bits and loads the identity.
// ----------------------------------------------------------------------------
module point_transform_perspective_divide
  import ptpd_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  reg_idx_t    cfg_index,
  input  logic [63:0] cfg_wdata
);

  localparam int VW = 2*COORD_WIDTH + 2;

  cfg_bank_t            cfg_r;
  logic                 en;
  logic                 v_valid, v_last;
  logic signed [VW-1:0] v [4];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_COL0_XY] <= RST_COL0_XY;
      cfg_r[REG_COL0_ZW] <= RST_COL0_ZW;
      cfg_r[REG_COL1_XY] <= RST_COL1_XY;
      cfg_r[REG_COL1_ZW] <= RST_COL1_ZW;
      cfg_r[REG_COL2_XY] <= RST_COL2_XY;
      cfg_r[REG_COL2_ZW] <= RST_COL2_ZW;
      cfg_r[REG_COL3_XY] <= RST_COL3_XY;
      cfg_r[REG_COL3_ZW] <= RST_COL3_ZW;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  ptpd_mac #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_WIDTH(COORD_WIDTH),
    .VW         (VW)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_valid),
    .in_data (in_data),
    .cfg     (cfg_r),
    .v_valid (v_valid),
    .v_last  (v_last),
    .v       (v)
  );

  ptpd_div #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_WIDTH(COORD_WIDTH),
    .VW         (VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_valid  (v_valid),
    .v_last   (v_last),
    .v        (v),
    .res_valid(out_valid),
    .res      (out_data)
  );

endmodule

/* design/ptpd_mac.sv */
// ----------------------------------------------------------------------------
// ptpd_mac
// Two-stage matrix-vector unit: twelve products, then row sums plus translation.
// ----------------------------------------------------------------------------
module ptpd_mac
  import ptpd_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32,
  parameter int VW          = 2*COORD_WIDTH+2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  in_t                  in_data,
  input  cfg_bank_t            cfg,
  output logic                 v_valid,
  output logic                 v_last,
  output logic signed [VW-1:0] v [4]
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2*COORD_WIDTH;

  function automatic logic signed [W-1:0] elem(input cfg_bank_t c, input int k);
    logic [31:0] half;
    half = k[0] ? c[k[3:1]][63:32] : c[k[3:1]][31:0];
    return $signed(half[W-1:0]);
  endfunction

  logic signed [W-1:0]  p [3];
  logic signed [PW-1:0] prod_r [4][3];
  logic signed [W-1:0]  trans_r [4];
  logic                 a_valid_r, a_last_r;
  logic                 b_valid_r, b_last_r;
  logic signed [VW-1:0] v_r [4];

  assign p[0] = $signed(in_data.px[W-1:0]);
  assign p[1] = $signed(in_data.py[W-1:0]);
  assign p[2] = $signed(in_data.pz[W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_last_r <= in_data.last_point;
      b_last_r <= a_last_r;
      for (int r = 0; r < 4; r++) begin
        trans_r[r] <= elem(cfg, 12 + r);
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= PW'(elem(cfg, c*4 + r)) * PW'(p[c]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        v_r[r] <= VW'(trans_r[r])
                + VW'(prod_r[r][0] >>> FRAC_BITS)
                + VW'(prod_r[r][1] >>> FRAC_BITS)
                + VW'(prod_r[r][2] >>> FRAC_BITS);
      end
    end
  end

  assign v_valid = b_valid_r;
  assign v_last  = b_last_r;
  assign v       = v_r;

endmodule

/* design/ptpd_div.sv */
// ----------------------------------------------------------------------------
// ptpd_div
// Pipelined restoring divider, one quotient bit per stage, three lanes with
// a shared divisor, followed by saturation.
// ----------------------------------------------------------------------------
module ptpd_div
  import ptpd_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32,
  parameter int VW          = 2*COORD_WIDTH+2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 v_valid,
  input  logic                 v_last,
  input  logic signed [VW-1:0] v [4],
  output logic                 res_valid,
  output out_t                 res
);

  localparam int W  = COORD_WIDTH;
  localparam int CW = VW + FRAC_BITS + W + 1;
  localparam int NS = W + 2;

  localparam logic [VW-1:0] ONE   = VW'(1) << FRAC_BITS;
  localparam logic [W:0]    HI_M  = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0]    LO_M  = {2'b01, {(W-1){1'b0}}};

  logic          valid_r [NS];
  logic          last_r  [NS];
  logic [VW-1:0] d_r     [NS];
  logic          wneg_r  [NS];
  logic          vneg_r  [NS][3];
  logic          ovf_r   [NS][3];
  logic [CW-1:0] rem_r   [NS][3];
  logic [W:0]    q_r     [NS][3];

  // stage 0: magnitudes and divisor select (w == 0 behaves as w == 1.0)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_r[0] <= v_last;
      wneg_r[0] <= v[3][VW-1];
      if (v[3] == '0) begin
        d_r[0] <= ONE;
      end else begin
        d_r[0] <= v[3][VW-1] ? VW'(-v[3]) : VW'(v[3]);
      end
      for (int i = 0; i < 3; i++) begin
        vneg_r[0][i] <= v[i][VW-1];
        ovf_r[0][i]  <= 1'b0;
        q_r[0][i]    <= '0;
        rem_r[0][i]  <= CW'(v[i][VW-1] ? VW'(-v[i]) : VW'(v[i])) << FRAC_BITS;
      end
    end
  end

  for (genvar s = 0; s < W + 1; s++) begin : g_stage
    localparam int K = W - s;
    logic [CW-1:0] dsh;
    logic [CW-1:0] dovf;
    assign dsh  = CW'(d_r[s]) << K;
    assign dovf = CW'(d_r[s]) << (W + 1);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s+1] <= 1'b0;
      end else if (en) begin
        valid_r[s+1] <= valid_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        last_r[s+1] <= last_r[s];
        d_r[s+1]    <= d_r[s];
        wneg_r[s+1] <= wneg_r[s];
        for (int i = 0; i < 3; i++) begin
          vneg_r[s+1][i] <= vneg_r[s][i];
          if (s == 0) begin
            ovf_r[s+1][i] <= (rem_r[s][i] >= dovf);
          end else begin
            ovf_r[s+1][i] <= ovf_r[s][i];
          end
          if (rem_r[s][i] >= dsh) begin
            rem_r[s+1][i] <= rem_r[s][i] - dsh;
            q_r[s+1][i]   <= {q_r[s][i][W-1:0], 1'b1};
          end else begin
            rem_r[s+1][i] <= rem_r[s][i];
            q_r[s+1][i]   <= {q_r[s][i][W-1:0], 1'b0};
          end
        end
      end
    end
  end

  // saturation and sign
  logic [W-1:0] r_w [3];
  logic [2:0]   sat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic neg;
      neg = vneg_r[NS-1][i] ^ wneg_r[NS-1];
      if (neg) begin
        sat[i] = ovf_r[NS-1][i] || (q_r[NS-1][i] > LO_M);
        r_w[i] = sat[i] ? {1'b1, {(W-1){1'b0}}} : W'(-q_r[NS-1][i]);
      end else begin
        sat[i] = ovf_r[NS-1][i] || (q_r[NS-1][i] > HI_M);
        r_w[i] = sat[i] ? {1'b0, {(W-1){1'b1}}} : q_r[NS-1][i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= valid_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.out_x     <= 32'($signed(r_w[0]));
      res.out_y     <= 32'($signed(r_w[1]));
      res.out_z     <= 32'($signed(r_w[2]));
      res.out_last  <= last_r[NS-1];
      res.saturated <= |sat;
    end
  end

endmodule

/* design/ptpd_checker.sv */
// ----------------------------------------------------------------------------
// ptpd_checker
// Port-level checks for the point transform block.
// ----------------------------------------------------------------------------
module ptpd_checker
  import ptpd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled transaction dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled payload changed");

endmodule

bind point_transform_perspective_divide ptpd_checker u_ptpd_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for point_transform_perspective_divide. Streams points through a
// series of matrix settings (identity, perspective, zero, all-ones, extreme,
// random) with random idling on both channels. Each result transaction is
// checked field by field against a fixed-point transform predictor or a directed table.
// ----------------------------------------------------------------------------
module tb;
  import ptpd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 37;
  localparam int IDLE_MAX  = 3000;
  localparam int PHASE_PTS = 75;
  localparam logic [31:0] ONE = 32'h0001_0000;

  typedef struct {
    in_t  pt;
    bit   typed;
    out_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  reg_idx_t    cfg_index = REG_COL0_XY;
  logic [63:0] cfg_wdata = '0;

  cfg_bank_t matrix;
  out_t      expected_q[$];
  int        errors = 0;
  int        points_sent = 0;
  int        results_seen = 0;
  int        sat_seen = 0;
  int        idle_cycles = 0;
  bit        quiet = 1'b0;
  bit        hold_req = 1'b0;

  point_transform_perspective_divide dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint clamp_coord(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint persp_div(longint v, longint w, inout bit sat);
    logic [127:0] a, d, q;
    bit neg;
    neg = (v < 0) != (w < 0);
    a = (v < 0) ? 128'(-v) : 128'(v);
    d = (w < 0) ? 128'(-w) : 128'(w);
    if (a / d >= 128'h1_0000_0000)
      return clamp_coord(neg ? -64'sd9223372036854775807 : 64'sd9223372036854775807, sat);
    q = (a << 16) / d;
    return clamp_coord(neg ? -longint'(q[63:0]) : longint'(q[63:0]), sat);
  endfunction

  function automatic out_t transform_point(in_t p, cfg_bank_t m);
    longint e[16];
    longint pv[3];
    longint v[4];
    logic signed [31:0] s32;
    longint r[3];
    bit sat;
    out_t o;
    sat = 1'b0;
    for (int k = 0; k < 16; k++) begin
      s32 = k[0] ? m[k[3:1]][63:32] : m[k[3:1]][31:0];
      e[k] = s32;
    end
    pv[0] = p.px;
    pv[1] = p.py;
    pv[2] = p.pz;
    for (int row = 0; row < 4; row++) begin
      v[row] = e[12 + row];
      for (int c = 0; c < 3; c++)
        v[row] += (e[c * 4 + row] * pv[c]) >>> 16;
    end
    for (int c = 0; c < 3; c++) begin
      if (v[3] != 0 && v[3] != longint'(ONE))
        r[c] = persp_div(v[c], v[3], sat);
      else
        r[c] = clamp_coord(v[c], sat);
    end
    o.out_x = r[0][31:0];
    o.out_y = r[1][31:0];
    o.out_z = r[2][31:0];
    o.out_last = p.last_point;
    o.saturated = sat;
    return o;
  endfunction

  // one point transaction; expectation queued on acceptance
  task automatic send_point(in_t p, bit typed = 1'b0, out_t res = '0);
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(typed ? res : transform_point(p, matrix));
    points_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic load_matrix(cfg_bank_t bank);
    drain();
    repeat (LATENCY + 3) @(posedge clk);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_wdata <= bank[i];
      @(posedge clk);
      matrix[i] = bank[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h0;
          1: return 32'h1;
          2: return 32'hFFFF_FFFF;
          3: return 32'h7FFF_FFFF;
          4: return 32'h8000_0000;
          default: return ONE;
        endcase
      end
    endcase
  endfunction

  function automatic cfg_bank_t rand_matrix();
    cfg_bank_t b;
    for (int i = 0; i < NUM_REGS; i++)
      b[i] = {rand_coord(), rand_coord()};
    return b;
  endfunction

  task automatic random_points(int n);
    in_t p;
    for (int i = 0; i < n; i++) begin
      p.px = rand_coord();
      p.py = rand_coord();
      p.pz = rand_coord();
      p.last_point = 1'($urandom_range(0, 1));
      send_point(p);
    end
  endtask

  // receiver stall pattern
  initial begin
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (hold_req) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data.saturated) sat_seen++;
        if (out_data.out_x !== exp_r.out_x) begin
          $error("out_x exp %h got %h", exp_r.out_x, out_data.out_x);
          errors++;
        end
        if (out_data.out_y !== exp_r.out_y) begin
          $error("out_y exp %h got %h", exp_r.out_y, out_data.out_y);
          errors++;
        end
        if (out_data.out_z !== exp_r.out_z) begin
          $error("out_z exp %h got %h", exp_r.out_z, out_data.out_z);
          errors++;
        end
        if (out_data.out_last !== exp_r.out_last) begin
          $error("out_last exp %b got %b", exp_r.out_last, out_data.out_last);
          errors++;
        end
        if (out_data.saturated !== exp_r.saturated) begin
          $error("saturated exp %b got %b", exp_r.saturated, out_data.saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("timeout: no transaction in %0d cycles", IDLE_MAX);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab[$];
    in_t p;
    cfg_bank_t bank;

    matrix = {RST_COL3_ZW, RST_COL3_XY, RST_COL2_ZW, RST_COL2_XY,
              RST_COL1_ZW, RST_COL1_XY, RST_COL0_ZW, RST_COL0_XY};
    // identity after reset: point passes through unchanged
    dir_tab.push_back('{'{32'h0, 32'h0, 32'h0, 1'b0}, 1'b1,
                        '{32'h0, 32'h0, 32'h0, 1'b0, 1'b0}});
    dir_tab.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1}, 1'b1,
                        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0}});
    dir_tab.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0}, 1'b1,
                        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0}});
    dir_tab.push_back('{'{32'hFFFF_FFFF, 32'h1, ONE, 1'b1}, 1'b1,
                        '{32'hFFFF_FFFF, 32'h1, ONE, 1'b1, 1'b0}});
    dir_tab.push_back('{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0, 1'b0}, 1'b0, '0});
    dir_tab.push_back('{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_0F0F, 1'b1}, 1'b0, '0});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_point(dir_tab[i].pt, dir_tab[i].typed, dir_tab[i].res);
    random_points(PHASE_PTS);

    // perspective: w = z, plus translation; small z gives huge quotients
    bank = '0;
    bank[REG_COL0_XY] = {32'h0, ONE};
    bank[REG_COL1_XY] = {ONE, 32'h0};
    bank[REG_COL2_ZW] = {ONE, ONE};
    bank[REG_COL3_XY] = {32'h0002_0000, 32'hFFFD_0000};
    load_matrix(bank);
    p = '{32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 1'b0};
    send_point(p);
    p = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b1};
    send_point(p);
    hold_req = 1'b1;
    random_points(PHASE_PTS);

    // zero matrix: w is zero, no divide
    load_matrix('0);
    random_points(PHASE_PTS / 2);

    load_matrix({NUM_REGS{64'hFFFF_FFFF_FFFF_FFFF}});
    random_points(PHASE_PTS / 2);

    load_matrix({NUM_REGS{64'h7FFF_FFFF_8000_0000}});
    random_points(PHASE_PTS);

    load_matrix(rand_matrix());
    random_points(PHASE_PTS / 2);
    drain();
    random_points(PHASE_PTS / 2);

    load_matrix(rand_matrix());
    random_points(PHASE_PTS);

    load_matrix(rand_matrix());
    quiet = 1'b1;
    random_points(PHASE_PTS);

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d points, %0d results (%0d saturated) over 8 matrix settings",
             points_sent, results_seen, sat_seen);
    if (errors == 0 && expected_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* point_transform_perspective_divide.f */
design/ptpd_pkg.sv
design/ptpd_mac.sv
design/ptpd_div.sv
design/point_transform_perspective_divide.sv
design/ptpd_checker.sv
sim/tb.sv
